@@ src/srf_pkg.sv @@
package srf_pkg;

  // Canvas size defaults
  localparam int DEF_ROWS = 20;
  localparam int DEF_COLS = 40;

  // Symbol held by every cell after reset ('_')
  localparam logic [7:0] RESET_BLANK = 8'd95;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } srf_op_e;

  localparam logic [2:0] SHAPE_LINE = 3'd1;
  localparam logic [2:0] SHAPE_RECT = 3'd2;
  localparam logic [2:0] SHAPE_RING = 3'd3;

  // One command as taken from the input channel
  typedef struct packed {
    logic [1:0]        opcode;
    logic [2:0]        shape_type;
    logic signed [7:0] x_start;
    logic signed [7:0] y_start;
    logic signed [7:0] x_end;
    logic signed [7:0] y_end;
    logic [7:0]        symbol;
    logic [4:0]        read_row;
    logic [5:0]        read_col;
  } srf_cmd_t;

  // Sequencer status toward the channel logic
  typedef struct packed {
    logic       idle;
    logic       done;
    logic [7:0] value;
  } srf_stat_t;

endpackage

@@ src/shape_rasterizer_framebuffer_unit.sv @@
// Character framebuffer with a shape rasterizer.
// Input channel (in_valid_i / in_ready_o) carries one command per transfer:
// clear the canvas, draw a line, rectangle outline or circle ring, or read
// one cell. Every command gives exactly one transfer on the output channel
// (out_valid_o / out_ready_i); cell_value_o: an in-grid read's cell, else 0.
// The config channel (cfg_valid_i / cfg_ready_o) sets the blank symbol used
// by clear; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. Commands are handled one
// at a time; in_ready_o is high only when idle. Clear and ring visit every
// canvas cell, a line walks its points and a rectangle visits its outline
// cells; a read or anything that draws nothing writes no cell. The cost of
// drawing is set by the single canvas write port: one cell per cycle.
// The ring test shares one squarer across its setup states ST_RSQ0 to
// ST_RSQ3, then tracks the squared distance with adds over the canvas scan.
// After reset the canvas is swept to '_', with in_ready_o low; config
// writes are taken meanwhile.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds its finished result and takes no new command.
module shape_rasterizer_framebuffer_unit #(
  parameter int CANVAS_ROWS = srf_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = srf_pkg::DEF_COLS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_blank_symbol_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [2:0]        shape_type_i,
  input  logic signed [7:0] x_start_i,
  input  logic signed [7:0] y_start_i,
  input  logic signed [7:0] x_end_i,
  input  logic signed [7:0] y_end_i,
  input  logic [7:0]        symbol_i,
  input  logic [4:0]        read_row_i,
  input  logic [5:0]        read_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        cell_value_o
);

  import srf_pkg::*;

  localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    blank_q;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  srf_cmd_t      cmd;
  srf_stat_t     stat;
  logic          slot_free;
  logic          in_xfer;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= RESET_BLANK;
    end else if (cfg_valid_i) begin
      blank_q <= cfg_blank_symbol_i;
    end
  end

  assign cmd.opcode = opcode_i;
  assign cmd.shape_type = shape_type_i;
  assign cmd.x_start = x_start_i;
  assign cmd.y_start = y_start_i;
  assign cmd.x_end = x_end_i;
  assign cmd.y_end = y_end_i;
  assign cmd.symbol = symbol_i;
  assign cmd.read_row = read_row_i;
  assign cmd.read_col = read_col_i;

  assign in_ready_o = stat.idle;
  assign in_xfer = in_valid_i && in_ready_o;

  // output register is free when empty or draining this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  srf_raster_seq #(
    .CANVAS_ROWS(CANVAS_ROWS),
    .CANVAS_COLS(CANVAS_COLS),
    .AW         (AW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .cmd_i    (cmd),
    .blank_i  (blank_q),
    .take_i   (slot_free),
    .stat_o   (stat),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data)
  );

  srf_canvas_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && slot_free) begin
      out_data_q <= stat.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_value_o = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("command accepted but block still ready");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done && slot_free |=> out_valid_o)
    else $error("finished result not presented");

  a_write_in_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, wr_addr} < (AW + 1)'(DEPTH)))
    else $error("canvas write outside the grid");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.idle |-> !wr_en)
    else $error("canvas written while idle");

endmodule

@@ src/srf_canvas_ram.sv @@
module srf_canvas_ram #(
  parameter int DEPTH = 800,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/srf_raster_seq.sv @@
module srf_raster_seq #(
  parameter int CANVAS_ROWS = srf_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = srf_pkg::DEF_COLS,
  parameter int AW = ((CANVAS_ROWS * CANVAS_COLS) > 1) ?
                     $clog2(CANVAS_ROWS * CANVAS_COLS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  srf_pkg::srf_cmd_t  cmd_i,
  input  logic [7:0]         blank_i,
  input  logic               take_i,
  output srf_pkg::srf_stat_t stat_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [7:0]         rd_data_i
);

  import srf_pkg::*;

  localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
  localparam int RW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int CW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam logic signed [8:0] ROWS_S = 9'(CANVAS_ROWS);
  localparam logic signed [8:0] COLS_S = 9'(CANVAS_COLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(CANVAS_COLS - 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_LSET, ST_LINE, ST_RECT,
    ST_RSQ0, ST_RSQ1, ST_RSQ2, ST_RSQ3, ST_RING, ST_READ, ST_DONE
  } state_e;

  state_e state_q, state_d;
  srf_cmd_t cmd_q, cmd_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] col_q, col_d;
  // line / rectangle walker
  logic signed [8:0]  px_q, px_d, py_q, py_d;
  logic signed [9:0]  ldx_q, ldx_d, ldy_q, ldy_d;
  logic               lsx_q, lsx_d, lsy_q, lsy_d;
  logic signed [10:0] err_q, err_d;
  // ring scan, squared distance kept incrementally
  logic signed [18:0] cx2_q, cx2_d, r2_q, r2_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [18:0] dxsq_q, dxsq_d, dysq_q, dysq_d;
  logic signed [9:0]  dxv_q, dxv_d, dyv_q, dyv_d;

  logic signed [8:0]  xs9, ys9, xe9, ye9;
  logic signed [9:0]  ddx, ddy, adx, ady;
  logic signed [11:0] e2;
  logic               step_x, step_y, line_end, rect_border;
  logic signed [8:0]  sq_op;
  logic signed [17:0] prod;
  logic signed [18:0] dsq, dxv_w, dyv_w;
  logic               ring_hit, row_end, last_cell;
  logic               plot_ok, rd_ok;
  logic [AW-1:0]      plot_addr;

  assign xs9 = 9'(cmd_q.x_start);
  assign ys9 = 9'(cmd_q.y_start);
  assign xe9 = 9'(cmd_q.x_end);
  assign ye9 = 9'(cmd_q.y_end);

  // Bresenham setup and step terms
  assign ddx = 10'(xe9) - 10'(xs9);
  assign ddy = 10'(ye9) - 10'(ys9);
  assign adx = ddx[9] ? -ddx : ddx;
  assign ady = ddy[9] ? -ddy : ddy;
  assign e2 = 12'(err_q) <<< 1;
  assign step_x = e2 >= 12'(ldy_q);
  assign step_y = e2 <= 12'(ldx_q);
  assign line_end = (px_q == xe9) && (py_q == ye9);
  assign rect_border = (py_q == ys9) || (py_q == ye9);

  // Shared squarer: center column, center row, radius in turn
  always_comb begin
    unique case (state_q)
      ST_RSQ0: sq_op = xs9;
      ST_RSQ1: sq_op = ys9;
      default: sq_op = xe9;
    endcase
  end
  assign prod = sq_op * sq_op;

  assign dsq = dxsq_q + dysq_q;
  assign ring_hit = (dsq >= lo_q) && (dsq <= hi_q);
  assign dxv_w = 19'(dxv_q);
  assign dyv_w = 19'(dyv_q);
  assign row_end = col_q == LAST_COL;
  assign last_cell = cnt_q == LAST_ADDR;

  // Clipping and linear address of the walker point
  assign plot_ok = (py_q >= 9'sd0) && (py_q < ROWS_S) && (px_q >= 9'sd0) && (px_q < COLS_S);
  assign plot_addr = AW'(AW'(py_q[RW-1:0]) * AW'(CANVAS_COLS) + AW'(px_q[CW-1:0]));

  assign rd_ok = (7'(cmd_q.read_row) < 7'(CANVAS_ROWS)) &&
                 (7'(cmd_q.read_col) < 7'(CANVAS_COLS));
  assign rd_en_o = state_q == ST_READ;
  assign rd_addr_o = AW'(AW'(cmd_q.read_row) * AW'(CANVAS_COLS) + AW'(cmd_q.read_col));

  always_comb begin
    wr_en_o = 1'b0;
    wr_addr_o = cnt_q;
    wr_data_o = cmd_q.symbol;
    unique case (state_q)
      ST_INIT: begin
        wr_en_o = 1'b1;
        wr_data_o = RESET_BLANK;
      end
      ST_CLEAR: begin
        wr_en_o = 1'b1;
        wr_data_o = blank_i;
      end
      ST_RING: wr_en_o = ring_hit;
      ST_LINE, ST_RECT: begin
        wr_en_o = plot_ok;
        wr_addr_o = plot_addr;
      end
      default: wr_en_o = 1'b0;
    endcase
  end

  assign stat_o.idle = state_q == ST_IDLE;
  assign stat_o.done = state_q == ST_DONE;
  assign stat_o.value = ((cmd_q.opcode == OP_READ) && rd_ok) ? rd_data_i : 8'd0;

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    col_d = col_q;
    px_d = px_q;
    py_d = py_q;
    ldx_d = ldx_q;
    ldy_d = ldy_q;
    lsx_d = lsx_q;
    lsy_d = lsy_q;
    err_d = err_q;
    cx2_d = cx2_q;
    r2_d = r2_q;
    lo_d = lo_q;
    hi_d = hi_q;
    dxsq_d = dxsq_q;
    dysq_d = dysq_q;
    dxv_d = dxv_q;
    dyv_d = dyv_q;
    unique case (state_q)
      ST_INIT: begin
        if (last_cell) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          cnt_d = '0;
          px_d = 9'(cmd_i.x_start);
          py_d = 9'(cmd_i.y_start);
          priority if (cmd_i.opcode == OP_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (cmd_i.opcode == OP_READ) begin
            state_d = ST_READ;
          end else if (cmd_i.opcode == OP_DRAW && cmd_i.shape_type == SHAPE_LINE) begin
            state_d = ST_LSET;
          end else if (cmd_i.opcode == OP_DRAW && cmd_i.shape_type == SHAPE_RING) begin
            state_d = ST_RSQ0;
          end else if (cmd_i.opcode == OP_DRAW && cmd_i.shape_type == SHAPE_RECT &&
                       cmd_i.x_start <= cmd_i.x_end && cmd_i.y_start <= cmd_i.y_end) begin
            state_d = ST_RECT;
          end else begin
            // reversed rectangle, unknown shape or opcode: nothing drawn
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        if (last_cell) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LSET: begin
        ldx_d = adx;
        ldy_d = -ady;
        lsx_d = xs9 < xe9;
        lsy_d = ys9 < ye9;
        err_d = 11'(adx) - 11'(ady);
        state_d = ST_LINE;
      end
      ST_LINE: begin
        if (line_end) begin
          state_d = ST_DONE;
        end else begin
          err_d = err_q + (step_x ? 11'(ldy_q) : 11'sd0) + (step_y ? 11'(ldx_q) : 11'sd0);
          if (step_x) begin
            px_d = lsx_q ? px_q + 9'sd1 : px_q - 9'sd1;
          end
          if (step_y) begin
            py_d = lsy_q ? py_q + 9'sd1 : py_q - 9'sd1;
          end
        end
      end
      ST_RECT: begin
        if (px_q == xe9) begin
          if (py_q == ye9) begin
            state_d = ST_DONE;
          end else begin
            py_d = py_q + 9'sd1;
            px_d = xs9;
          end
        end else if (rect_border || px_q != xs9) begin
          px_d = px_q + 9'sd1;
        end else begin
          // interior row: left edge then straight to right edge
          px_d = xe9;
        end
      end
      ST_RSQ0: begin
        cx2_d = 19'(prod);
        state_d = ST_RSQ1;
      end
      ST_RSQ1: begin
        dysq_d = 19'(prod);
        state_d = ST_RSQ2;
      end
      ST_RSQ2: begin
        r2_d = 19'(prod);
        state_d = ST_RSQ3;
      end
      ST_RSQ3: begin
        lo_d = r2_q - 19'(xe9);
        hi_d = r2_q + 19'(xe9);
        dxsq_d = cx2_q;
        dxv_d = -10'(xs9);
        dyv_d = -10'(ys9);
        cnt_d = '0;
        col_d = '0;
        state_d = ST_RING;
      end
      ST_RING: begin
        if (last_cell) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (row_end) begin
            col_d = '0;
            dxsq_d = cx2_q;
            dxv_d = -10'(xs9);
            dysq_d = dysq_q + dyv_w + dyv_w + 19'sd1;
            dyv_d = dyv_q + 10'sd1;
          end else begin
            col_d = col_q + 1'b1;
            dxsq_d = dxsq_q + dxv_w + dxv_w + 19'sd1;
            dxv_d = dxv_q + 10'sd1;
          end
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    col_q <= col_d;
    px_q <= px_d;
    py_q <= py_d;
    ldx_q <= ldx_d;
    ldy_q <= ldy_d;
    lsx_q <= lsx_d;
    lsy_q <= lsy_d;
    err_q <= err_d;
    cx2_q <= cx2_d;
    r2_q <= r2_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    dxsq_q <= dxsq_d;
    dysq_q <= dysq_d;
    dxv_q <= dxv_d;
    dyv_q <= dyv_d;
  end

endmodule
